/* design/text_screen_editor_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text screen editor
// Concurrent check wrappers clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_SCREEN_EDITOR_TOP_ASSERT_SVH
`define TEXT_SCREEN_EDITOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Plain property check.
`define TSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a result in the next cycle.
`define TSE_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define TSE_ASSERT(lbl, prop, msg)
`define TSE_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

/* design/tse_pkg.sv */
// ----------------------------------------------------------------------------
// Text screen editor package
// Screen geometry, character codes, control word layout and helper functions.
// ----------------------------------------------------------------------------
package tse_pkg;

   // Screen geometry.
   localparam int COLUMNS = 40;
   localparam int ROWS    = 24;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(CELLS);

   // Field widths fixed by the interface.
   localparam int ROW_W  = 5;
   localparam int COL_W  = 6;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 10;
   localparam int CMD_W  = 2;

   // Program counter width of the sequencer.
   localparam int PC_W = 5;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOME = 2'd2;

   // Control characters.
   localparam logic [CHAR_W-1:0] CH_UP    = 8'h1C;
   localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h1D;
   localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h1E;
   localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h1F;
   localparam logic [CHAR_W-1:0] CH_CLEAR = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_EOL   = 8'h9B;

   // Inverse-video bit that shows the cursor.
   localparam logic [CHAR_W-1:0] MARK_BIT = 8'h80;

   // Margin reset values.
   localparam logic [COL_W-1:0] LM_RESET = 6'd2;
   localparam logic [COL_W-1:0] RM_RESET = 6'd39;

   // Memory read address source.
   typedef enum logic [1:0] {
      RD_NONE,
      RD_CURSOR,
      RD_INDEX,
      RD_AHEAD
   } rd_sel_type;

   // Memory write source.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_UNMARK,
      WR_CHAR,
      WR_MARK,
      WR_ZERO,
      WR_COPY
   } wr_sel_type;

   // Cursor update.
   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_CTRL,
      CUR_ADVANCE,
      CUR_HOME
   } cur_op_type;

   // Sweep pointer update.
   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_STEP
   } ptr_op_type;

   // Sequencer branch kinds; a conditional branch falls through to the next step.
   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_DISPATCH,
      JMP_SCROLL,
      JMP_NOSCROLL,
      JMP_FILL,
      JMP_COPY
   } jmp_type;

   // One microcode word.
   typedef struct packed {
      rd_sel_type       rd;
      wr_sel_type       wr;
      cur_op_type       cur;
      ptr_op_type       ptr;
      logic             mark_off;
      logic             respond;
      logic             rsp_read;
      jmp_type          jmp;
      logic [PC_W-1:0]  target;
   } cw_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic              accept;
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] code;
      logic              scroll;
      logic              fill_more;
      logic              copy_more;
      logic              stall;
   } seq_status_type;

   // A margin beyond the last column acts as the last column.
   function automatic logic [COL_W-1:0] eff_margin(input logic [COL_W-1:0] m);
      if (32'(m) > COLUMNS - 1) return COL_W'(COLUMNS - 1);
      return m;
   endfunction

   // ASCII to screen code, bit 7 kept.
   function automatic logic [CHAR_W-1:0] map_code(input logic [CHAR_W-1:0] c);
      logic [6:0] low;
      logic [6:0] s;
      low = c[6:0];
      if (low < 7'h20) s = low + 7'h40;
      else if (low < 7'h60) s = low - 7'h20;
      else s = low;
      return {c[7], s};
   endfunction

endpackage

/* design/tse_sequencer.sv */
// ----------------------------------------------------------------------------
// Text screen editor sequencer
// Step counter and microcode store that drive the screen datapath.
// ----------------------------------------------------------------------------
module tse_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  tse_pkg::seq_status_type status,
   output tse_pkg::cw_type         cw
);
   import tse_pkg::*;

   // Step addresses of the program.
   localparam logic [PC_W-1:0] ST_BOOT = 5'd0;
   localparam logic [PC_W-1:0] ST_IDLE = 5'd1;
   localparam logic [PC_W-1:0] ST_RD0  = 5'd2;
   localparam logic [PC_W-1:0] ST_RD1  = 5'd3;
   localparam logic [PC_W-1:0] ST_NOP  = 5'd4;
   localparam logic [PC_W-1:0] ST_CHR0 = 5'd5;
   localparam logic [PC_W-1:0] ST_MRK0 = 5'd6;
   localparam logic [PC_W-1:0] ST_MRK1 = 5'd7;
   localparam logic [PC_W-1:0] ST_CTL0 = 5'd8;
   localparam logic [PC_W-1:0] ST_CTL1 = 5'd9;
   localparam logic [PC_W-1:0] ST_SCR0 = 5'd10;
   localparam logic [PC_W-1:0] ST_SCR1 = 5'd11;
   localparam logic [PC_W-1:0] ST_SCR2 = 5'd12;
   localparam logic [PC_W-1:0] ST_SCR3 = 5'd13;
   localparam logic [PC_W-1:0] ST_SCRJ = 5'd14;
   localparam logic [PC_W-1:0] ST_CLR0 = 5'd15;
   localparam logic [PC_W-1:0] ST_CLR1 = 5'd16;
   localparam logic [PC_W-1:0] ST_CLRJ = 5'd17;

   localparam cw_type CW_BLANK = '{
      rd: RD_NONE, wr: WR_NONE, cur: CUR_HOLD, ptr: PTR_HOLD, mark_off: 1'b0,
      respond: 1'b0, rsp_read: 1'b0, jmp: JMP_NEXT, target: ST_IDLE
   };

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take_branch;

   // Microcode store: one control word per step.
   function automatic cw_type ucode(input logic [PC_W-1:0] a);
      cw_type w;
      w = CW_BLANK;
      case (a)
         // Clear the whole store after reset.
         ST_BOOT: begin
            w.wr = WR_ZERO; w.ptr = PTR_STEP; w.jmp = JMP_FILL; w.target = ST_BOOT;
         end
         ST_IDLE: begin
            w.jmp = JMP_DISPATCH; w.target = ST_IDLE;
         end
         // Read one cell.
         ST_RD0: begin
            w.rd = RD_INDEX;
         end
         ST_RD1: begin
            w.respond = 1'b1; w.rsp_read = 1'b1; w.jmp = JMP_GOTO;
         end
         ST_NOP: begin
            w.respond = 1'b1; w.jmp = JMP_GOTO;
         end
         // Store a character over the marked cell and advance.
         ST_CHR0: begin
            w.wr = WR_CHAR; w.cur = CUR_ADVANCE; w.ptr = PTR_CLEAR;
            w.jmp = JMP_SCROLL; w.target = ST_SCR0;
         end
         // Mark the new cursor cell and answer.
         ST_MRK0: begin
            w.rd = RD_CURSOR;
         end
         ST_MRK1: begin
            w.wr = WR_MARK; w.respond = 1'b1; w.jmp = JMP_GOTO;
         end
         // Cursor motion: unmark, move, maybe scroll.
         ST_CTL0: begin
            w.rd = RD_CURSOR;
         end
         ST_CTL1: begin
            w.wr = WR_UNMARK; w.cur = CUR_CTRL; w.ptr = PTR_CLEAR;
            w.jmp = JMP_NOSCROLL; w.target = ST_MRK0;
         end
         // Scroll: copy each row up, then zero the bottom row.
         ST_SCR0: begin
            w.rd = RD_AHEAD; w.ptr = PTR_STEP;
         end
         ST_SCR1: begin
            w.rd = RD_AHEAD; w.wr = WR_COPY; w.ptr = PTR_STEP;
            w.jmp = JMP_COPY; w.target = ST_SCR1;
         end
         ST_SCR2: begin
            w.wr = WR_COPY;
         end
         ST_SCR3: begin
            w.wr = WR_ZERO; w.ptr = PTR_STEP; w.jmp = JMP_FILL; w.target = ST_SCR3;
         end
         ST_SCRJ: begin
            w.jmp = JMP_GOTO; w.target = ST_MRK0;
         end
         // Clear screen and home the cursor.
         ST_CLR0: begin
            w.cur = CUR_HOME; w.ptr = PTR_CLEAR; w.mark_off = 1'b1;
         end
         ST_CLR1: begin
            w.wr = WR_ZERO; w.ptr = PTR_STEP; w.jmp = JMP_FILL; w.target = ST_CLR1;
         end
         ST_CLRJ: begin
            w.jmp = JMP_GOTO; w.target = ST_MRK0;
         end
         default: begin
            w.jmp = JMP_GOTO;
         end
      endcase
      return w;
   endfunction

   // First step of the routine for a request.
   function automatic logic [PC_W-1:0] entry_of(input logic [CMD_W-1:0] cmd,
                                                input logic [CHAR_W-1:0] code);
      logic [PC_W-1:0] e;
      case (cmd)
         CMD_PUT: begin
            if (code == CH_CLEAR) e = ST_CLR0;
            else if (code inside {CH_UP, CH_DOWN, CH_LEFT, CH_RIGHT, CH_TAB, CH_EOL})
               e = ST_CTL0;
            else e = ST_CHR0;
         end
         CMD_READ: e = ST_RD0;
         CMD_HOME: e = ST_CTL0;
         default:  e = ST_NOP;
      endcase
      return e;
   endfunction

   assign cw = ucode(pc_ff);

   // Branch condition of the current word.
   always_comb begin
      case (cw.jmp)
         JMP_GOTO:     take_branch = 1'b1;
         JMP_SCROLL:   take_branch = status.scroll;
         JMP_NOSCROLL: take_branch = !status.scroll;
         JMP_FILL:     take_branch = status.fill_more;
         JMP_COPY:     take_branch = status.copy_more;
         default:      take_branch = 1'b0;
      endcase
   end

   // Next step.
   always_comb begin
      if (status.stall) begin
         pc_in = pc_ff;
      end else if (cw.jmp == JMP_DISPATCH) begin
         pc_in = status.accept ? entry_of(status.cmd, status.code) : pc_ff;
      end else if (take_branch) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_BOOT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* design/text_screen_editor_top.sv */
// ----------------------------------------------------------------------------
// Text screen editor, top level
// Character screen store with cursor, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------
//  req     | in        | req_tvalid / req_tready | tuser command, tdata char+index
//  rsp     | out       | rsp_tvalid / rsp_tready | tdata cell_data, row, col
//  csr     | in        | APB, pready always high | left_margin @0, right_margin @4
//
//  A request is taken only while the sequencer waits in its idle step. Clear
//  screen and scroll sweep the store through the single write port of the
//  screen memory, one cell per cycle. After reset the memory is cleared before
//  the first request is taken; configuration writes are taken throughout.
//  A result waits in the output register; the next request is taken meanwhile,
//  and the sequencer stalls only when a second result is ready.
//
`include "text_screen_editor_top_assert.svh"

module text_screen_editor_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], cell_index[17:8], zero fill
   input  logic [1:0]  req_tuser,   // command[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // cell_data[7:0], cursor_row[12:8],
                                    // cursor_col[18:13], zero fill
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tse_pkg::*;

   localparam logic REG_LEFT_MARGIN  = 1'b0;
   localparam logic REG_RIGHT_MARGIN = 1'b1;

   cw_type          cw;
   seq_status_type  status;

   logic [COL_W-1:0]  lm_ff;
   logic [COL_W-1:0]  rm_ff;
   logic [COL_W-1:0]  lm_eff;
   logic [COL_W-1:0]  rm_eff;

   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic              mark_shown_ff;
   logic              mark_shown_in;
   logic [ADDR_W-1:0] ptr_ff;
   logic [ADDR_W-1:0] ptr_in;

   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] code_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [CHAR_W-1:0] screen_mem [CELLS];
   logic [CHAR_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;

   logic [ADDR_W-1:0] cursor_addr;
   logic [COL_W:0]    col_up;
   logic [COL_W:0]    col_tab;
   logic              scroll;
   logic              idx_ok;
   logic              accept;
   logic              step_en;
   logic              rsp_load;
   logic              cfg_write;

   logic              rsp_tvalid_ff;
   logic              rsp_tvalid_in;
   logic [CHAR_W-1:0] rsp_data_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;

   // Sequencer.
   tse_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   // Handshake and step control.
   assign req_tready = (cw.jmp == JMP_DISPATCH);
   assign accept     = req_tvalid && req_tready;
   assign step_en    = !(cw.respond && rsp_tvalid_ff && !rsp_tready);
   assign rsp_load   = step_en && cw.respond;

   assign status.accept    = accept;
   assign status.cmd       = req_tuser;
   assign status.code      = req_tdata[7:0];
   assign status.scroll    = scroll;
   assign status.fill_more = (ptr_ff != ADDR_W'(CELLS - 1));
   assign status.copy_more = (ptr_ff != ADDR_W'(CELLS - COLUMNS - 1));
   assign status.stall     = !step_en;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_RIGHT_MARGIN) ? {26'd0, rm_ff}
                                                          : {26'd0, lm_ff};
   assign lm_eff = eff_margin(lm_ff);
   assign rm_eff = eff_margin(rm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lm_ff <= LM_RESET;
         rm_ff <= RM_RESET;
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_LEFT_MARGIN) lm_ff <= csr_pwdata[COL_W-1:0];
         else rm_ff <= csr_pwdata[COL_W-1:0];
      end
   end

   // Request fields held for the routine.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser;
         code_ff <= req_tdata[7:0];
         idx_ff  <= req_tdata[17:8];
      end
   end

   assign idx_ok      = (32'(idx_ff) < 32'(CELLS));
   assign cursor_addr = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));

   // Cursor update and scroll detection.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      scroll  = 1'b0;
      col_up  = {1'b0, col_ff} + (COL_W+1)'(1);
      col_tab = {1'b0, col_ff[COL_W-1:3], 3'b000} + (COL_W+1)'(8);
      case (cw.cur)
         CUR_HOME: begin
            row_in = '0;
            col_in = lm_eff;
         end
         CUR_ADVANCE: begin
            if (col_up > {1'b0, rm_eff} || col_up > (COL_W+1)'(COLUMNS - 1)) begin
               col_in = lm_eff;
               if (row_ff == ROW_W'(ROWS - 1)) scroll = 1'b1;
               else row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_up[COL_W-1:0];
            end
         end
         CUR_CTRL: begin
            if (cmd_ff == CMD_HOME) begin
               row_in = '0;
               col_in = lm_eff;
            end else begin
               case (code_ff)
                  CH_UP:    if (row_ff != '0) row_in = row_ff - ROW_W'(1);
                  CH_DOWN:  if (row_ff < ROW_W'(ROWS - 1)) row_in = row_ff + ROW_W'(1);
                  CH_LEFT:  if (col_ff != '0) col_in = col_ff - COL_W'(1);
                  CH_RIGHT: if (col_ff < COL_W'(COLUMNS - 1)) col_in = col_ff + COL_W'(1);
                  CH_TAB: begin
                     col_in = (col_tab > (COL_W+1)'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                                 : col_tab[COL_W-1:0];
                  end
                  CH_EOL: begin
                     col_in = lm_eff;
                     if (row_ff == ROW_W'(ROWS - 1)) scroll = 1'b1;
                     else row_in = row_ff + ROW_W'(1);
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Sweep pointer and cursor mark flag.
   always_comb begin
      case (cw.ptr)
         PTR_CLEAR: ptr_in = '0;
         PTR_STEP:  ptr_in = ptr_ff + ADDR_W'(1);
         default:   ptr_in = ptr_ff;
      endcase
      case (cw.wr)
         WR_UNMARK, WR_CHAR: mark_shown_in = 1'b0;
         WR_MARK:            mark_shown_in = 1'b1;
         default:            mark_shown_in = cw.mark_off ? 1'b0 : mark_shown_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= eff_margin(LM_RESET);
         mark_shown_ff <= 1'b0;
         ptr_ff        <= '0;
      end else if (step_en) begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         mark_shown_ff <= mark_shown_in;
         ptr_ff        <= ptr_in;
      end
   end

   // Memory port selection.
   always_comb begin
      case (cw.rd)
         RD_INDEX: rd_addr = ADDR_W'(idx_ff);
         RD_AHEAD: rd_addr = ptr_ff + ADDR_W'(COLUMNS);
         default:  rd_addr = cursor_addr;
      endcase
      rd_en = step_en && (cw.rd != RD_NONE) && !(cw.rd == RD_INDEX && !idx_ok);

      wr_addr = cursor_addr;
      wr_data = rd_data_ff ^ MARK_BIT;
      case (cw.wr)
         WR_UNMARK: wr_en = step_en && mark_shown_ff;
         WR_MARK:   wr_en = step_en;
         WR_CHAR: begin
            wr_en   = step_en;
            wr_data = map_code(code_ff);
         end
         WR_ZERO: begin
            wr_en   = step_en;
            wr_addr = ptr_ff;
            wr_data = '0;
         end
         WR_COPY: begin
            wr_en   = step_en;
            wr_addr = ptr_ff - ADDR_W'(1);
            wr_data = rd_data_ff;
         end
         default:   wr_en = 1'b0;
      endcase
   end

   // Screen memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) screen_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= screen_mem[rd_addr];
   end

   // Output register.
   assign rsp_tvalid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= (cw.rsp_read && idx_ok) ? rd_data_ff : '0;
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, rsp_col_ff, rsp_row_ff, rsp_data_ff};

   // Checks.
   `TSE_ASSERT(a_rsp_slot_free, rsp_load |-> (!rsp_tvalid_ff || rsp_tready), "result overwrites a pending result")
   `TSE_ASSERT_NEXT(a_mark_after_put, rsp_load && (cmd_ff == CMD_PUT || cmd_ff == CMD_HOME), mark_shown_ff, "cursor cell not marked after put or home")
   `TSE_ASSERT(a_no_rw_collision, (rd_en && wr_en) |-> (rd_addr != wr_addr), "memory read and write hit the same cell")
   `TSE_ASSERT_NEXT(a_cursor_idle_stable, req_tready && !req_tvalid, $stable(row_ff) && $stable(col_ff), "cursor moved while idle")

endmodule

/* tb/sv/text_screen_editor_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text screen editor testbench
// Sends put, read, home and unused commands on the request stream. Each reply
// is checked against a testbench screen and cursor predictor or a typed row.
// The margins are rewritten between runs of random traffic, and both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module text_screen_editor_top_tb;
   import tse_pkg::*;

   // Unused command code; the block answers it without changing anything.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // Register byte addresses.
   localparam logic [2:0] REG_LEFT_MARGIN  = 3'd0;
   localparam logic [2:0] REG_RIGHT_MARGIN = 3'd4;

   localparam int CYCLE_LIMIT    = 5_000_000;
   localparam int LONG_HOLD      = 400;
   localparam int PHASES         = 10;
   localparam int PHASE_REQUESTS = 100;
   localparam int DIRECTED_ROWS  = 26;
   localparam int MAX_PRINTED    = 40;

   // One reply as it appears on the response stream.
   typedef struct packed {
      logic [7:0] cell_data;
      logic [4:0] row;
      logic [5:0] col;
   } screen_reply_type;

   // One row of the directed table; typed rows carry their own expected reply.
   typedef struct packed {
      logic [1:0]       cmd;
      logic [7:0]       code;
      logic [9:0]       index;
      logic             typed;
      screen_reply_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted screen store, cursor and margins.
   logic [7:0]  screen_mem [CELLS];
   logic [4:0]  cur_row;
   logic [5:0]  cur_col;
   int          mark_addr;
   logic        mark_on;
   logic [5:0]  lm_reg;
   logic [5:0]  rm_reg;

   screen_reply_type expected_replies [$];
   directed_row_type directed_rows [DIRECTED_ROWS];

   int  mismatch_count = 0;
   int  replies_seen = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  idle_enable = 1'b1;
   bit  hold_request = 1'b0;

   text_screen_editor_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A margin past the last column behaves as the last column.
   function automatic logic [5:0] margin_col(input logic [5:0] m);
      return (m > 6'(COLUMNS - 1)) ? 6'(COLUMNS - 1) : m;
   endfunction

   // Bits 6:5 select a block of 32 codes: block 0 moves to 2, 1 to 0, 2 to 1,
   // and block 3 stays. Bit 7 passes through.
   function automatic logic [7:0] to_screen_code(input logic [7:0] c);
      case (c[6:5])
         2'b00: return {c[7], 2'b10, c[4:0]};
         2'b01: return {c[7], 2'b00, c[4:0]};
         2'b10: return {c[7], 2'b01, c[4:0]};
         default: return c;
      endcase
   endfunction

   // Left margin of the next row; the last row scrolls the screen up instead.
   task automatic new_line();
      cur_col = margin_col(lm_reg);
      if (cur_row == 5'(ROWS - 1)) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = '0;
      end else begin
         cur_row++;
      end
   endtask

   task automatic clear_cursor_mark();
      if (mark_on) screen_mem[mark_addr] ^= MARK_BIT;
      mark_on = 1'b0;
   endtask

   task automatic set_cursor_mark();
      mark_addr = int'(cur_row) * COLUMNS + int'(cur_col);
      screen_mem[mark_addr] ^= MARK_BIT;
      mark_on = 1'b1;
   endtask

   // Advances the predicted screen by one request and returns its reply.
   task automatic apply_request(input logic [1:0] cmd, input logic [7:0] code,
                                input logic [9:0] idx, output screen_reply_type reply);
      int next_col;
      int tab_stop;
      reply = '0;
      case (cmd)
         CMD_PUT: begin
            clear_cursor_mark();
            case (code)
               CH_UP: begin
                  if (cur_row != 0) cur_row--;
               end
               CH_DOWN: begin
                  if (cur_row < ROWS - 1) cur_row++;
               end
               CH_LEFT: begin
                  if (cur_col != 0) cur_col--;
               end
               CH_RIGHT: begin
                  if (cur_col < COLUMNS - 1) cur_col++;
               end
               CH_CLEAR: begin
                  foreach (screen_mem[i]) screen_mem[i] = '0;
                  cur_row = '0;
                  cur_col = margin_col(lm_reg);
               end
               CH_TAB: begin
                  tab_stop = (int'(cur_col) & ~7) + 8;
                  cur_col = (tab_stop > COLUMNS - 1) ? 6'(COLUMNS - 1) : 6'(tab_stop);
               end
               CH_EOL: begin
                  new_line();
               end
               default: begin
                  screen_mem[int'(cur_row) * COLUMNS + int'(cur_col)] = to_screen_code(code);
                  next_col = int'(cur_col) + 1;
                  if (next_col > int'(margin_col(rm_reg)) || next_col > COLUMNS - 1)
                     new_line();
                  else
                     cur_col = 6'(next_col);
               end
            endcase
            set_cursor_mark();
         end
         CMD_READ: begin
            if (idx < CELLS) reply.cell_data = screen_mem[idx];
         end
         CMD_HOME: begin
            clear_cursor_mark();
            cur_row = '0;
            cur_col = margin_col(lm_reg);
            set_cursor_mark();
         end
         default: begin
         end
      endcase
      reply.row = cur_row;
      reply.col = cur_col;
   endtask

   // Offers one request, possibly after a gap, and records its expected reply.
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] code,
                               input logic [9:0] idx, input logic typed,
                               input screen_reply_type typed_reply);
      screen_reply_type predicted;
      int gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, idx, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(cmd, code, idx, predicted);
      expected_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Stops offering and waits until every expected reply has come back.
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // APB write with random upper bits; only the low six bits hold the margin.
   task automatic write_margin(input logic [2:0] addr, input logic [5:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {26'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == REG_LEFT_MARGIN) lm_reg = value;
      else rm_reg = value;
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t: reply %0d: %s", $time, replies_seen, what);
   endtask

   // Reply side readiness: random stalls, plus one long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each accepted reply with the oldest expectation.
   always @(posedge clock) begin : reply_check
      screen_reply_type seen;
      screen_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tdata[7:0], rsp_tdata[12:8], rsp_tdata[18:13]};
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("reply %h with nothing expected", seen));
         end else begin
            want = expected_replies.pop_front();
            if (seen.cell_data !== want.cell_data)
               report_mismatch($sformatf("cell_data %h, expected %h",
                                         seen.cell_data, want.cell_data));
            if (seen.row !== want.row)
               report_mismatch($sformatf("cursor_row %0d, expected %0d", seen.row, want.row));
            if (seen.col !== want.col)
               report_mismatch($sformatf("cursor_col %0d, expected %0d", seen.col, want.col));
         end
         replies_seen++;
      end
   end

   // Run time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int         sent;
      int         kind;
      int         n;
      int         phase_left [PHASES];
      int         phase_right [PHASES];
      logic [1:0] cmd;
      logic [7:0] code;
      logic [9:0] idx;

      // Predicted state after reset.
      foreach (screen_mem[i]) screen_mem[i] = '0;
      cur_row   = '0;
      cur_col   = LM_RESET;
      lm_reg    = LM_RESET;
      rm_reg    = RM_RESET;
      mark_addr = 0;
      mark_on   = 1'b0;

      // Directed requests under the reset margins.
      directed_rows = '{
         '{CMD_READ,  8'h00,  10'd0,    1'b1, '{8'h00, 5'd0, 6'd2}},
         '{CMD_READ,  8'hFF,  10'd959,  1'b1, '{8'h00, 5'd0, 6'd2}},
         '{CMD_READ,  8'h00,  10'd1023, 1'b1, '{8'h00, 5'd0, 6'd2}},
         '{CMD_SPARE, 8'hFF,  10'd1023, 1'b1, '{8'h00, 5'd0, 6'd2}},
         '{CMD_PUT,   8'h41,  10'd0,    1'b1, '{8'h00, 5'd0, 6'd3}},
         '{CMD_READ,  8'h00,  10'd2,    1'b1, '{8'h21, 5'd0, 6'd3}},
         '{CMD_READ,  8'h00,  10'd3,    1'b1, '{8'h80, 5'd0, 6'd3}},
         '{CMD_PUT,   8'h00,  10'h3FF,  1'b0, '0},
         '{CMD_PUT,   8'hFF,  10'd0,    1'b0, '0},
         '{CMD_PUT,   8'h60,  10'd0,    1'b0, '0},
         '{CMD_PUT,   8'hA0,  10'd0,    1'b0, '0},
         '{CMD_PUT,   CH_UP,    10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_LEFT,  10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_RIGHT, 10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_DOWN,  10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_TAB,   10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_TAB,   10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_TAB,   10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_TAB,   10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_TAB,   10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_RIGHT, 10'd0,  1'b0, '0},
         '{CMD_PUT,   8'h7A,    10'd0,  1'b0, '0},
         '{CMD_PUT,   CH_EOL,   10'd0,  1'b0, '0},
         '{CMD_HOME,  8'h00,    10'd0,  1'b1, '{8'h00, 5'd0, 6'd2}},
         '{CMD_PUT,   CH_CLEAR, 10'd0,  1'b1, '{8'h00, 5'd0, 6'd2}},
         '{CMD_READ,  8'h00,    10'd2,  1'b1, '{8'h80, 5'd0, 6'd2}}
      };

      // Margin settings per phase; -1 picks a random 6-bit value.
      phase_left  = '{0, 39, 63, 5, 20, 0, 39, -1, -1, 2};
      phase_right = '{39, 0, 63, 12, 30, 0, 39, -1, -1, 39};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_request(directed_rows[r].cmd, directed_rows[r].code, directed_rows[r].index,
                      directed_rows[r].typed, directed_rows[r].want);

      for (int p = 0; p < PHASES; p++) begin
         // Margins change only once the block is idle.
         wait_for_replies();
         idle_enable = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         write_margin(REG_LEFT_MARGIN,
                      (phase_left[p] < 0) ? 6'($urandom_range(0, 63)) : 6'(phase_left[p]));
         write_margin(REG_RIGHT_MARGIN,
                      (phase_right[p] < 0) ? 6'($urandom_range(0, 63)) : 6'(phase_right[p]));
         if (p == 1) hold_request = 1'b1;

         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               // A line of text, usually closed by an end of line.
               n = $urandom_range(1, 45);
               repeat (n)
                  send_request(CMD_PUT, 8'($urandom_range(0, 255)),
                               10'($urandom_range(0, 1023)), 1'b0, '0);
               if ($urandom_range(0, 9) < 7) begin
                  send_request(CMD_PUT, CH_EOL, 10'($urandom_range(0, 1023)), 1'b0, '0);
                  n++;
               end
            end else if (kind < 57) begin
               // Cursor motions and tabs.
               n = $urandom_range(1, 8);
               repeat (n) begin
                  case ($urandom_range(0, 4))
                     0: code = CH_UP;
                     1: code = CH_DOWN;
                     2: code = CH_LEFT;
                     3: code = CH_RIGHT;
                     default: code = CH_TAB;
                  endcase
                  send_request(CMD_PUT, code, 10'($urandom_range(0, 1023)), 1'b0, '0);
               end
            end else if (kind < 62) begin
               // Down to the last row so that later text scrolls.
               n = ROWS - 1;
               repeat (n) send_request(CMD_PUT, CH_DOWN, '0, 1'b0, '0);
            end else if (kind < 80) begin
               // Cell reads: under the cursor, anywhere, or past the screen.
               n = $urandom_range(1, 6);
               repeat (n) begin
                  case ($urandom_range(0, 3))
                     0: idx = 10'(int'(cur_row) * COLUMNS + int'(cur_col));
                     1: idx = 10'($urandom_range(CELLS, 1023));
                     default: idx = 10'($urandom_range(0, CELLS - 1));
                  endcase
                  send_request(CMD_READ, 8'($urandom_range(0, 255)), idx, 1'b0, '0);
               end
            end else if (kind < 86) begin
               n = 1;
               send_request(CMD_HOME, 8'($urandom_range(0, 255)),
                            10'($urandom_range(0, 1023)), 1'b0, '0);
            end else if (kind < 88) begin
               n = 1;
               send_request(CMD_PUT, CH_CLEAR, 10'($urandom_range(0, 1023)), 1'b0, '0);
            end else if (kind < 92) begin
               n = 1;
               send_request(CMD_SPARE, 8'($urandom_range(0, 255)),
                            10'($urandom_range(0, 1023)), 1'b0, '0);
            end else begin
               // Fully random request.
               n = 1;
               cmd = 2'($urandom_range(0, 3));
               send_request(cmd, 8'($urandom_range(0, 255)),
                            10'($urandom_range(0, 1023)), 1'b0, '0);
            end
            sent += n;
         end
      end

      // Drain, then allow for a late clear or scroll before the verdict.
      wait_for_replies();
      repeat (2 * CELLS) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
